### rtl/assert_macros.svh
// Assertion macros shared by the SHA-256 hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never be true outside reset.
`define SHS_ASSERT_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SHS_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/shs_pkg.sv
// Types, constants and round functions shared by the SHA-256 hasher.
`default_nettype none

package shs_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int BLOCK_BYTES  = 64;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int WORD_W       = 32;
    localparam int FILL_W       = $clog2(BLOCK_BYTES);
    localparam int WADDR_W      = $clog2(BLOCK_WORDS);
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int WIDX_W       = $clog2(DIGEST_WORDS);
    localparam int COUNT_W      = 61;

    localparam logic [7:0]        PAD_BYTE   = 8'h80;
    localparam logic [FILL_W-1:0] LEN_OFFSET = FILL_W'(56);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] chain_t;

    // Requests from the byte sequencer to the compression unit
    typedef struct packed {
        logic start;
        logic reinit;
    } shs_ctrl_t;

    // Status back from the compression unit
    typedef struct packed {
        logic busy;
        logic done;
    } shs_stat_t;

    localparam word_t H_INIT [0:DIGEST_WORDS-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

### rtl/shs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/shs_round_unit.sv
// SHA-256 compression unit: one round per cycle, chaining words and schedule window.
`default_nettype none
`include "assert_macros.svh"

module shs_round_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire shs_pkg::shs_ctrl_t            ctrl_i,
    output shs_pkg::shs_stat_t                 stat_o,
    output logic [shs_pkg::WADDR_W-1:0]        raddr_o,
    input  wire shs_pkg::word_t                rdata_i,
    output shs_pkg::chain_t                    chain_o
);
    import shs_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE  = 5'b00001,
        U_LOAD0 = 5'b00010,
        U_LOAD1 = 5'b00100,
        U_ROUND = 5'b01000,
        U_FINAL = 5'b10000
    } unit_state_t;

    unit_state_t                       state_reg, state_next;
    logic [ROUND_W-1:0]                round_reg, round_next;
    chain_t                            chain_reg, chain_next;
    chain_t                            vars_reg, vars_next;
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] win_reg, win_next;
    word_t                             wt_reg, wt_next;
    word_t                             t1, t2, ch, mj, w_ext;

    // Round arithmetic on the working variables a..h
    always_comb begin
        ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        mj    = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2]) ^
                (vars_reg[1] & vars_reg[2]);
        t1    = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + ROUND_K[round_reg] + wt_reg;
        t2    = big_sigma0(vars_reg[0]) + mj;
        w_ext = small_sigma1(win_reg[15]) + win_reg[10] + small_sigma0(win_reg[2]) +
                win_reg[1];
    end

    // Sequencer: load, 64 rounds, fold into the chaining words
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        vars_next  = vars_reg;
        win_next   = win_reg;
        wt_next    = wt_reg;
        raddr_o    = '0;
        unique case (state_reg)
            U_IDLE: begin
                if (ctrl_i.reinit) begin
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        chain_next[i] = H_INIT[i];
                    end
                end
                if (ctrl_i.start) begin
                    state_next = U_LOAD0;
                end
            end
            U_LOAD0: begin
                vars_next  = chain_reg;
                state_next = U_LOAD1;
            end
            U_LOAD1: begin
                raddr_o    = WADDR_W'(1);
                wt_next    = rdata_i;
                state_next = U_ROUND;
            end
            U_ROUND: begin
                raddr_o = round_reg[WADDR_W-1:0] + WADDR_W'(2);
                // Prepare the schedule word for the next round
                wt_next = (round_reg < ROUND_W'(BLOCK_WORDS - 1)) ? rdata_i : w_ext;
                win_next = {wt_reg, win_reg[BLOCK_WORDS-1:1]};
                vars_next[7] = vars_reg[6];
                vars_next[6] = vars_reg[5];
                vars_next[5] = vars_reg[4];
                vars_next[4] = vars_reg[3] + t1;
                vars_next[3] = vars_reg[2];
                vars_next[2] = vars_reg[1];
                vars_next[1] = vars_reg[0];
                vars_next[0] = t1 + t2;
                round_next   = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_W'(ROUNDS - 1)) begin
                    state_next = U_FINAL;
                end
            end
            U_FINAL: begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Control and chaining registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            round_reg <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_reg[i] <= H_INIT[i];
            end
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    // Working variables and schedule window
    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
        win_reg  <= win_next;
        wt_reg   <= wt_next;
    end

    assign stat_o.busy = (state_reg != U_IDLE);
    assign stat_o.done = (state_reg == U_FINAL);
    assign chain_o     = chain_reg;

    `SHS_ASSERT_NEVER(a_round_outside, aclk, aresetn,
        (state_reg != U_ROUND) && (round_reg != '0), "round count left nonzero")
    `SHS_ASSERT_NEVER(a_start_busy, aclk, aresetn,
        ctrl_i.start && (state_reg != U_IDLE), "block start while compressing")

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// A byte is taken whenever s_tready is high; the 64th byte of a block holds s_tready
// low while the one-round-per-cycle compression unit runs (2 load, 64 rounds, 1 fold).
// End of message: the pad bytes (9 to 72) go into the block buffer, each padded block
// is compressed in turn, then the eight digest words leave as eight m_ beats.
// Reset (aresetn low, synchronous) restores the initial hash words and clears the byte
// count, fill and sequencer; the block buffer RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic             m_tlast    // last_word
);
    import shs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_HASH = 4'b0100,
        ST_EMIT = 4'b1000
    } top_state_t;

    top_state_t           state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [23:0]          acc_reg, acc_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 pad_started_reg, pad_started_next;
    logic                 len_phase_reg, len_phase_next;
    logic                 eom_reg, eom_next;
    logic                 len_done_reg, len_done_next;
    logic [WIDX_W-1:0]    widx_reg, widx_next;

    logic                 s_accept, m_accept;
    logic                 put_en, block_full, len_sel;
    logic [7:0]           put_byte, pad_byte;
    logic [7:0][7:0]      len_bytes;
    shs_ctrl_t            ctrl;
    shs_stat_t            stat;
    logic [WADDR_W-1:0]   raddr;
    word_t                rdata;
    chain_t               chain;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Pick the next padding byte: marker, zero fill or big-endian bit length
    assign len_bytes = {count_reg, 3'b000};
    assign len_sel   = pad_started_reg && ((fill_reg == LEN_OFFSET) || len_phase_reg);
    always_comb begin
        if (!pad_started_reg) begin
            pad_byte = PAD_BYTE;
        end else if (len_sel) begin
            pad_byte = len_bytes[~fill_reg[2:0]];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Feed message or pad bytes into the block buffer
    always_comb begin
        put_en   = 1'b0;
        put_byte = s_tdata;
        if (state_reg == ST_IDLE) begin
            put_en = s_accept && s_tuser;
        end else if (state_reg == ST_PAD) begin
            put_en   = 1'b1;
            put_byte = pad_byte;
        end
    end
    assign block_full = put_en && (fill_reg == FILL_W'(BLOCK_BYTES - 1));

    // Sequencer for absorb, pad, compress and emit
    always_comb begin
        state_next       = state_reg;
        fill_next        = put_en ? fill_reg + FILL_W'(1) : fill_reg;
        acc_next         = put_en ? {acc_reg[15:0], put_byte} : acc_reg;
        count_next       = count_reg;
        pad_started_next = pad_started_reg;
        len_phase_next   = len_phase_reg;
        eom_next         = eom_reg;
        len_done_next    = len_done_reg;
        widx_next        = widx_reg;
        ctrl.start       = block_full;
        ctrl.reinit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    eom_next = s_tlast;
                    if (s_tuser) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (block_full) begin
                        state_next = ST_HASH;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                pad_started_next = 1'b1;
                if (len_sel) begin
                    len_phase_next = 1'b1;
                    if (block_full) begin
                        len_done_next = 1'b1;
                    end
                end
                if (block_full) begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (stat.done) begin
                    if (len_done_reg) begin
                        state_next = ST_EMIT;
                    end else if (eom_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (m_accept) begin
                    widx_next = widx_reg + WIDX_W'(1);
                    if (widx_reg == WIDX_W'(DIGEST_WORDS - 1)) begin
                        // Drop message state and restart the chain
                        ctrl.reinit      = 1'b1;
                        count_next       = '0;
                        pad_started_next = 1'b0;
                        len_phase_next   = 1'b0;
                        eom_next         = 1'b0;
                        len_done_next    = 1'b0;
                        state_next       = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            count_reg       <= '0;
            pad_started_reg <= 1'b0;
            len_phase_reg   <= 1'b0;
            eom_reg         <= 1'b0;
            len_done_reg    <= 1'b0;
            widx_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            count_reg       <= count_next;
            pad_started_reg <= pad_started_next;
            len_phase_reg   <= len_phase_next;
            eom_reg         <= eom_next;
            len_done_reg    <= len_done_next;
            widx_reg        <= widx_next;
        end
    end

    // Partial word of the block buffer
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Block buffer, one 32-bit big-endian word per four bytes
    shs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (put_en && (fill_reg[1:0] == 2'b11)),
        .waddr (fill_reg[FILL_W-1:2]),
        .wdata ({acc_reg, put_byte}),
        .raddr (raddr),
        .rdata (rdata)
    );

    shs_round_unit u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_i  (ctrl),
        .stat_o  (stat),
        .raddr_o (raddr),
        .rdata_i (rdata),
        .chain_o (chain)
    );

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'b00000, widx_reg, chain[widx_reg]};
    assign m_tlast  = (widx_reg == WIDX_W'(DIGEST_WORDS - 1));

    `SHS_ASSERT_NEVER(a_both_sides, aclk, aresetn,
        s_tready && m_tvalid, "input taken while digest is out")
    `SHS_ASSERT_IMPL(a_emit_empty, aclk, aresetn,
        m_tvalid, fill_reg == '0, "digest out with bytes left in buffer")
    `SHS_ASSERT_IMPL(a_busy_hash, aclk, aresetn,
        stat.busy, state_reg == ST_HASH, "compression outside hash state")

endmodule

`default_nettype wire

### tb/sha256_stream_hasher_checker.sv
// Checker for the SHA-256 stream hasher: predicts digests from accepted requests and compares.
`timescale 1ns / 1ps

module sha256_stream_hasher_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    input  logic        m_tlast,   // last_word
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Predicted hasher state
    logic [31:0]  chain_h   [8];
    logic [7:0]   blk_bytes [64];
    int           blk_fill;
    logic [60:0]  msg_bytes;
    digest_beat_t digest_q  [$];

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the full block buffer into the chaining words
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, wt, s0, s1;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                s0 = rotr32(w[(r+1)%16], 7) ^ rotr32(w[(r+1)%16], 18) ^ (w[(r+1)%16] >> 3);
                s1 = rotr32(w[(r+14)%16], 17) ^ rotr32(w[(r+14)%16], 19)
                     ^ (w[(r+14)%16] >> 10);
                wt = w[r%16] + s0 + w[(r+9)%16] + s1;
                w[r%16] = wt;
            end
            t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
                 + ((e & f) ^ (~e & g)) + SHA_K[r] + wt;
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] val);
        blk_bytes[blk_fill] = val;
        blk_fill++;
        if (blk_fill == 64) begin
            compress_block();
            blk_fill = 0;
        end
    endfunction

    function automatic void restart_hash();
        chain_h   = SHA_IV;
        blk_fill  = 0;
        msg_bytes = '0;
    endfunction

    // Apply one accepted request; on end of message queue the eight digest words
    function automatic void take_request(input logic [7:0] val, input logic present,
                                         input logic eom);
        logic [63:0]  bit_len;
        digest_beat_t beat;
        int i;
        if (present) begin
            absorb_byte(val);
            msg_bytes = msg_bytes + 61'd1;
        end
        if (eom) begin
            bit_len = {msg_bytes, 3'b000};
            absorb_byte(8'h80);
            while (blk_fill != 56)
                absorb_byte(8'h00);
            for (i = 0; i < 8; i++)
                absorb_byte(bit_len[63-8*i -: 8]);
            for (i = 0; i < 8; i++) begin
                beat.word  = chain_h[i];
                beat.index = 3'(i);
                beat.last  = (i == 7);
                digest_q.push_back(beat);
            end
            restart_hash();
        end
    endfunction

    initial begin
        mismatches  = 0;
        outstanding = 0;
        restart_hash();
    end

    // Track requests and check every accepted result beat against the oldest prediction
    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (!aresetn) begin
            restart_hash();
            digest_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_request(s_tdata[7:0], s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected result: digest_word %h word_index %0d last_word %b",
                           m_tdata[31:0], m_tdata[34:32], m_tlast);
                    mismatches++;
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_tdata[31:0] !== exp_beat.word) begin
                        $error("digest_word: expected %h, actual %h",
                               exp_beat.word, m_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_tdata[34:32] !== exp_beat.index) begin
                        $error("word_index: expected %0d, actual %0d",
                               exp_beat.index, m_tdata[34:32]);
                        mismatches++;
                    end
                    if (m_tlast !== exp_beat.last) begin
                        $error("last_word: expected %b, actual %b", exp_beat.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = digest_q.size();
    end

endmodule

### tb/sha256_stream_hasher_tb.sv
// Top of the SHA-256 stream hasher testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

    localparam int RANDOM_ITEMS = 330;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 500000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;
    bit hold_go     = 1'b0;
    bit hold_active = 1'b0;

    sha256_stream_hasher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha256_stream_hasher_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Favor short messages and the lengths around the padding boundaries
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 12);
        if (r < 75) begin
            case ($urandom_range(0, 7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 120;
            endcase
        end
        if (r < 92)
            return $urandom_range(13, 130);
        return $urandom_range(121, 200);
    endfunction

    // Offer one request and hold it until accepted; returns at a falling edge
    task automatic push_item(input logic [7:0] val, input logic present, input logic eom,
                             input bit no_gap);
        int gap;
        s_tdata  = val;
        s_tuser  = present;
        s_tlast  = eom;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (present || eom)
            items_sent++;
        @(negedge aclk);
        if (!no_gap) begin
            gap = pick_gap();
            if (gap > 0) begin
                s_tvalid = 1'b0;
                s_tdata  = 8'($urandom_range(0, 255));
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Send a message of random bytes, sprinkled with ignored requests unless in a burst
    task automatic send_message(input int len, input bit burst);
        int  k;
        bit  fold_last;
        fold_last = (len > 0) && ($urandom_range(0, 1) == 1);
        for (k = 0; k < len; k++) begin
            if (!burst && $urandom_range(0, 9) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst);
            push_item(8'($urandom_range(0, 255)), 1'b1, fold_last && (k == len - 1), burst);
        end
        if (!fold_last)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst);
    endtask

    // Result side: random stalls, bursts of readiness, and one long hold on request
    initial begin : result_sink
        int r;
        int n;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_go) begin
                m_tready    = 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_go     = 1'b0;
                hold_active = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready = 1'b1;
                    n = $urandom_range(1, 24);
                end else if (r < 92) begin
                    m_tready = 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    m_tready = 1'b0;
                    n = $urandom_range(10, 150);
                end
                repeat (n) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int msg_no;
        int k;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty request, empty message, ignored bytes, data extremes
        push_item(8'hff, 1'b0, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0, 1'b0);
        push_item(8'h5a, 1'b0, 1'b0, 1'b0);
        push_item(8'hc3, 1'b0, 1'b1, 1'b0);
        push_item(8'h61, 1'b1, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1, 1'b1);
        push_item(8'hff, 1'b0, 1'b1, 1'b1);

        // Drain before going random
        s_tvalid = 1'b0;
        wait (outstanding == 0);
        @(negedge aclk);

        items_sent = 0;
        msg_no     = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (msg_no == 1) begin
                // Stall the result side for a long stretch while requests keep coming
                s_tvalid = 1'b0;
                hold_go  = 1'b1;
                wait (hold_active);
                @(negedge aclk);
                for (k = 0; k < 4; k++)
                    send_message($urandom_range(1, 6), 1'b1);
            end else if (msg_no % 8 == 6) begin
                // Pause until every digest is out
                s_tvalid = 1'b0;
                wait (outstanding == 0);
                @(negedge aclk);
            end
            send_message(pick_length(), $urandom_range(0, 3) == 0);
            msg_no++;
        end
        s_tvalid = 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
